FILE: hw/rtl/mlem_pkg.sv
// Shared types and constants of the MLEM reconstruction engine.
`timescale 1ns / 1ps

package mlem_pkg;

  // Item operation codes.
  localparam logic [1:0] OP_LOAD_MATRIX = 2'd0;
  localparam logic [1:0] OP_LOAD_IMAGE  = 2'd1;
  localparam logic [1:0] OP_START       = 2'd2;
  localparam logic [1:0] OP_READ        = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_IMAGE_BINS  = 2'd0;
  localparam logic [1:0] REG_OBJECT_BINS = 2'd1;
  localparam logic [1:0] REG_ITERATIONS  = 2'd2;

  // Register reset values.
  localparam logic [8:0] IMAGE_BINS_RST  = 9'd256;
  localparam logic [8:0] OBJECT_BINS_RST = 9'd256;
  localparam logic [6:0] ITERATIONS_RST  = 7'd0;

  // 1.0 in Q16.16.
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  // Datapath widths: accumulators, dividend and divisor of the divider.
  localparam int ACC_W = 64;
  localparam int NUM_W = 96;
  localparam int DEN_W = 64;
  localparam int QUO_W = 32;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  image_index;
    logic [7:0]  object_index;
    logic [31:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [31:0] estimate;
  } out_item_t;

endpackage

FILE: hw/rtl/mlem_reconstruction_engine.sv
// Top level of the MLEM reconstruction engine: item handling, registers and sequencer.
`timescale 1ns / 1ps

// Channel   Ports                               Beat
// input     in_valid, in_stall, in_data         one load, start or read item
// result    out_valid, out_stall, out_data      status and estimate, one per item
// config    psel, penable, pwrite, paddr, ...   one 32-bit register write or read
//
// Load items leave the sequencer idle; a read passes through S_READ (registered memory read).
// A start runs the column sums and then each iteration's projections, through the single
// matrix memory port and the bit-serial divider. Reset is synchronous; the estimate memory
// reads as zero until the first start. The input stalls while the sequencer is not idle
// or a result waits on out_stall; otherwise a new item enters each cycle.
module mlem_reconstruction_engine #(
  parameter int IMAGE_BINS     = 256,
  parameter int OBJECT_BINS    = 256,
  parameter int MAX_ITERATIONS = 100
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mlem_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mlem_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int IMG_AW = (IMAGE_BINS > 1) ? $clog2(IMAGE_BINS) : 1;
  localparam int OBJ_AW = (OBJECT_BINS > 1) ? $clog2(OBJECT_BINS) : 1;
  localparam int H_DEPTH = IMAGE_BINS * OBJECT_BINS;
  localparam int HA_W = (H_DEPTH > 1) ? $clog2(H_DEPTH) : 1;
  localparam int MAX_BINS = (IMAGE_BINS > OBJECT_BINS) ? IMAGE_BINS : OBJECT_BINS;
  localparam int CNT_W = $clog2(MAX_BINS + 1);
  localparam int IT_W = $clog2(MAX_ITERATIONS + 1);
  localparam int CS_W = 32 + IMG_AW;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_READ    = 13'b0000000000010,
    S_INIT    = 13'b0000000000100,
    S_CS_RUN  = 13'b0000000001000,
    S_ITER    = 13'b0000000010000,
    S_FP_RUN  = 13'b0000000100000,
    S_FP_WAIT = 13'b0000001000000,
    S_BP_RUN  = 13'b0000010000000,
    S_BP_M1   = 13'b0000100000000,
    S_BP_M2   = 13'b0001000000000,
    S_BP_M3   = 13'b0010000000000,
    S_BP_WAIT = 13'b0100000000000,
    S_COPY    = 13'b1000000000000
  } state_t;

  // Configuration registers.
  logic [8:0] cfg_img_r, cfg_img_nxt;
  logic [8:0] cfg_obj_r, cfg_obj_nxt;
  logic [6:0] cfg_iter_r, cfg_iter_nxt;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    cfg_img_nxt  = cfg_img_r;
    cfg_obj_nxt  = cfg_obj_r;
    cfg_iter_nxt = cfg_iter_r;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        mlem_pkg::REG_IMAGE_BINS:  cfg_img_nxt  = pwdata[8:0];
        mlem_pkg::REG_OBJECT_BINS: cfg_obj_nxt  = pwdata[8:0];
        mlem_pkg::REG_ITERATIONS:  cfg_iter_nxt = pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      mlem_pkg::REG_IMAGE_BINS:  prdata = 32'(cfg_img_r);
      mlem_pkg::REG_OBJECT_BINS: prdata = 32'(cfg_obj_r);
      mlem_pkg::REG_ITERATIONS:  prdata = 32'(cfg_iter_r);
      default:                   prdata = '0;
    endcase
  end

  // Bins and iterations in effect, clamped to the built sizes.
  logic [CNT_W-1:0] n_img, n_obj;
  logic [IT_W-1:0]  iter_lim;

  assign n_img = (32'(cfg_img_r) > IMAGE_BINS) ? CNT_W'(IMAGE_BINS) : CNT_W'(cfg_img_r);
  assign n_obj = (32'(cfg_obj_r) > OBJECT_BINS) ? CNT_W'(OBJECT_BINS) : CNT_W'(cfg_obj_r);
  assign iter_lim = (32'(cfg_iter_r) > MAX_ITERATIONS) ? IT_W'(MAX_ITERATIONS)
                                                       : IT_W'(cfg_iter_r);

  // Sequencer registers.
  state_t                      state_r, state_nxt;
  logic [CNT_W-1:0]            o_r, o_nxt;
  logic [CNT_W-1:0]            k_r, k_nxt;
  logic [IT_W-1:0]             iter_r, iter_nxt;
  logic [mlem_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [63:0]                 prod_r, prod_nxt;
  logic [63:0]                 lo_r, lo_nxt;
  logic                        v1_r, v2_r, issue;
  logic                        copy_v_r, copy_v_nxt;
  logic [CNT_W-1:0]            copy_addr_r;
  logic                        est_valid_r, est_valid_nxt;
  logic                        out_valid_r, out_valid_nxt;
  mlem_pkg::out_item_t         out_data_r, out_data_nxt;

  // Input acceptance and index checks.
  logic accept, img_ok, obj_ok;

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign img_ok   = 32'(in_data.image_index) < 32'(n_img);
  assign obj_ok   = 32'(in_data.object_index) < 32'(n_obj);

  // Memory ports.
  logic                 h_we;
  logic [HA_W-1:0]      h_waddr, h_raddr;
  logic [31:0]          h_rdata;
  logic                 img_we;
  logic [23:0]          img_rdata;
  logic                 est_we;
  logic [OBJ_AW-1:0]    est_waddr, est_raddr;
  logic [31:0]          est_wdata, est_rdata;
  logic                 cs_we;
  logic [CS_W-1:0]      cs_rdata;
  logic                 w_we;
  logic [31:0]          w_rdata;
  logic                 nx_we;
  logic [31:0]          nx_rdata;

  // Divider interface.
  logic                       div_start, div_done;
  logic [mlem_pkg::NUM_W-1:0] div_num;
  logic [mlem_pkg::DEN_W-1:0] div_den;
  logic [31:0]                div_quot;

  // Matrix address: row is the detector bin, column the voxel.
  logic [CNT_W-1:0] h_row, h_col;

  assign h_we    = accept && (in_data.operation == mlem_pkg::OP_LOAD_MATRIX) && img_ok && obj_ok;
  assign h_waddr = HA_W'(32'(in_data.image_index) * OBJECT_BINS + 32'(in_data.object_index));
  assign h_row   = (state_r == S_FP_RUN) ? o_r : k_r;
  assign h_col   = (state_r == S_FP_RUN) ? k_r : o_r;
  assign h_raddr = HA_W'(32'(h_row) * OBJECT_BINS + 32'(h_col));
  assign img_we  = accept && (in_data.operation == mlem_pkg::OP_LOAD_IMAGE) && img_ok;

  // Estimate port: read item address when idle, voxel loop in forward projection.
  always_comb begin
    unique case (state_r)
      S_IDLE:   est_raddr = OBJ_AW'(in_data.object_index);
      S_FP_RUN: est_raddr = OBJ_AW'(k_r);
      default:  est_raddr = OBJ_AW'(o_r);
    endcase
  end

  assign est_we    = (state_r == S_INIT) || copy_v_r;
  assign est_waddr = (state_r == S_INIT) ? OBJ_AW'(o_r) : OBJ_AW'(copy_addr_r);
  assign est_wdata = (state_r == S_INIT) ? mlem_pkg::ONE_Q16 : nx_rdata;

  // Shared 32x32 multiplier operands.
  logic [31:0] mul_a, mul_b;

  always_comb begin
    unique case (state_r)
      S_BP_M1:  mul_a = acc_r[31:0];
      S_BP_M2:  mul_a = acc_r[63:32];
      default:  mul_a = h_rdata;
    endcase
    unique case (state_r)
      S_CS_RUN: mul_b = 32'd1;
      S_BP_RUN: mul_b = w_rdata;
      default:  mul_b = est_rdata;
    endcase
  end

  assign prod_nxt = (v1_r || (state_r == S_BP_M1) || (state_r == S_BP_M2))
                  ? 64'(mul_a) * 64'(mul_b) : prod_r;

  // Inner loop bound and drain detection.
  logic [CNT_W-1:0] n_inner;
  logic             inner_left, drained;

  assign n_inner    = (state_r == S_FP_RUN) ? n_obj : n_img;
  assign inner_left = k_r < n_inner;
  assign drained    = !inner_left && !v1_r && !v2_r;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    o_nxt         = o_r;
    k_nxt         = k_r;
    iter_nxt      = iter_r;
    acc_nxt       = acc_r;
    lo_nxt        = lo_r;
    est_valid_nxt = est_valid_r;
    issue         = 1'b0;
    div_start     = 1'b0;
    div_num       = '0;
    div_den       = '0;
    cs_we         = 1'b0;
    w_we          = 1'b0;
    nx_we         = 1'b0;
    if (v2_r) begin
      acc_nxt = acc_r + ((state_r == S_CS_RUN) ? prod_r : (prod_r >> 16));
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.operation == mlem_pkg::OP_START) begin
            o_nxt         = '0;
            iter_nxt      = '0;
            est_valid_nxt = 1'b1;
            state_nxt     = S_INIT;
          end else if ((in_data.operation == mlem_pkg::OP_READ) && obj_ok) begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: state_nxt = S_IDLE;
      S_INIT: begin
        if (o_r == CNT_W'(OBJECT_BINS - 1)) begin
          o_nxt     = '0;
          k_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = (n_obj == '0) ? S_ITER : S_CS_RUN;
        end else begin
          o_nxt = o_r + 1'b1;
        end
      end
      S_CS_RUN: begin
        if (inner_left) begin
          issue = 1'b1;
          k_nxt = k_r + 1'b1;
        end else if (drained) begin
          cs_we = 1'b1;
          if (({1'b0, o_r} + 1'b1) < {1'b0, n_obj}) begin
            o_nxt   = o_r + 1'b1;
            k_nxt   = '0;
            acc_nxt = '0;
          end else begin
            state_nxt = S_ITER;
          end
        end
      end
      S_ITER: begin
        o_nxt   = '0;
        k_nxt   = '0;
        acc_nxt = '0;
        if ((iter_r >= iter_lim) || (n_obj == '0)) begin
          state_nxt = S_IDLE;
        end else begin
          iter_nxt  = iter_r + 1'b1;
          state_nxt = (n_img == '0) ? S_BP_RUN : S_FP_RUN;
        end
      end
      S_FP_RUN: begin
        if (inner_left) begin
          issue = 1'b1;
          k_nxt = k_r + 1'b1;
        end else if (drained) begin
          div_start = 1'b1;
          div_num   = mlem_pkg::NUM_W'(img_rdata) << 48;
          div_den   = acc_r;
          state_nxt = S_FP_WAIT;
        end
      end
      S_FP_WAIT: begin
        if (div_done) begin
          w_we    = 1'b1;
          k_nxt   = '0;
          acc_nxt = '0;
          if (({1'b0, o_r} + 1'b1) < {1'b0, n_img}) begin
            o_nxt     = o_r + 1'b1;
            state_nxt = S_FP_RUN;
          end else begin
            o_nxt     = '0;
            state_nxt = S_BP_RUN;
          end
        end
      end
      S_BP_RUN: begin
        if (inner_left) begin
          issue = 1'b1;
          k_nxt = k_r + 1'b1;
        end else if (drained) begin
          state_nxt = S_BP_M1;
        end
      end
      S_BP_M1: state_nxt = S_BP_M2;
      S_BP_M2: begin
        lo_nxt    = prod_r;
        state_nxt = S_BP_M3;
      end
      S_BP_M3: begin
        div_start = 1'b1;
        div_num   = {prod_r, 32'd0} + mlem_pkg::NUM_W'(lo_r);
        div_den   = mlem_pkg::DEN_W'(cs_rdata);
        state_nxt = S_BP_WAIT;
      end
      S_BP_WAIT: begin
        if (div_done) begin
          nx_we   = 1'b1;
          k_nxt   = '0;
          acc_nxt = '0;
          if (({1'b0, o_r} + 1'b1) < {1'b0, n_obj}) begin
            o_nxt     = o_r + 1'b1;
            state_nxt = S_BP_RUN;
          end else begin
            o_nxt     = '0;
            state_nxt = S_COPY;
          end
        end
      end
      S_COPY: begin
        if (o_r < n_obj) begin
          o_nxt = o_r + 1'b1;
        end else if (!copy_v_r) begin
          state_nxt = S_ITER;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign copy_v_nxt = (state_r == S_COPY) && (o_r < n_obj);

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (accept && !((in_data.operation == mlem_pkg::OP_READ) && obj_ok)) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.estimate = '0;
      case (in_data.operation)
        mlem_pkg::OP_LOAD_MATRIX: out_data_nxt.status = !(img_ok && obj_ok);
        mlem_pkg::OP_LOAD_IMAGE:  out_data_nxt.status = !img_ok;
        mlem_pkg::OP_READ:        out_data_nxt.status = 1'b1;
        default:                  out_data_nxt.status = 1'b0;
      endcase
    end else if (state_r == S_READ) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.status   = 1'b0;
      out_data_nxt.estimate = est_valid_r ? est_rdata : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_img_r   <= mlem_pkg::IMAGE_BINS_RST;
      cfg_obj_r   <= mlem_pkg::OBJECT_BINS_RST;
      cfg_iter_r  <= mlem_pkg::ITERATIONS_RST;
      state_r     <= S_IDLE;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      copy_v_r    <= 1'b0;
      est_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      o_r         <= '0;
      k_r         <= '0;
      iter_r      <= '0;
    end else begin
      cfg_img_r   <= cfg_img_nxt;
      cfg_obj_r   <= cfg_obj_nxt;
      cfg_iter_r  <= cfg_iter_nxt;
      state_r     <= state_nxt;
      v1_r        <= issue;
      v2_r        <= v1_r;
      copy_v_r    <= copy_v_nxt;
      est_valid_r <= est_valid_nxt;
      out_valid_r <= out_valid_nxt;
      o_r         <= o_nxt;
      k_r         <= k_nxt;
      iter_r      <= iter_nxt;
    end
    acc_r       <= acc_nxt;
    prod_r      <= prod_nxt;
    lo_r        <= lo_nxt;
    copy_addr_r <= o_r;
    out_data_r  <= out_data_nxt;
  end

  // System matrix.
  mlem_ram #(.WIDTH(32), .DEPTH(H_DEPTH)) u_h_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (in_data.load_value),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  // Detector image counts.
  mlem_ram #(.WIDTH(24), .DEPTH(IMAGE_BINS)) u_img_ram (
    .clk   (clk),
    .we    (img_we),
    .waddr (IMG_AW'(in_data.image_index)),
    .wdata (in_data.load_value[23:0]),
    .raddr (IMG_AW'(o_r)),
    .rdata (img_rdata)
  );

  // Voxel estimates.
  mlem_ram #(.WIDTH(32), .DEPTH(OBJECT_BINS)) u_est_ram (
    .clk   (clk),
    .we    (est_we),
    .waddr (est_waddr),
    .wdata (est_wdata),
    .raddr (est_raddr),
    .rdata (est_rdata)
  );

  // Column sums of the matrix.
  mlem_ram #(.WIDTH(CS_W), .DEPTH(OBJECT_BINS)) u_cs_ram (
    .clk   (clk),
    .we    (cs_we),
    .waddr (OBJ_AW'(o_r)),
    .wdata (CS_W'(acc_r)),
    .raddr (OBJ_AW'(o_r)),
    .rdata (cs_rdata)
  );

  // Image weighted by the inverse projection.
  mlem_ram #(.WIDTH(32), .DEPTH(IMAGE_BINS)) u_w_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (IMG_AW'(o_r)),
    .wdata (div_quot),
    .raddr (IMG_AW'(k_r)),
    .rdata (w_rdata)
  );

  // Estimates of the update in progress.
  mlem_ram #(.WIDTH(32), .DEPTH(OBJECT_BINS)) u_nx_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (OBJ_AW'(o_r)),
    .wdata (div_quot),
    .raddr (OBJ_AW'(o_r)),
    .rdata (nx_rdata)
  );

  mlem_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

endmodule

FILE: hw/rtl/mlem_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module mlem_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/mlem_div.sv
// Sequential saturating divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module mlem_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [mlem_pkg::NUM_W-1:0]      num,
  input  logic [mlem_pkg::DEN_W-1:0]      den,
  output logic                            done,
  output logic [mlem_pkg::QUO_W-1:0]      quot
);

  typedef enum logic [2:0] {
    D_IDLE  = 3'b001,
    D_CHECK = 3'b010,
    D_RUN   = 3'b100
  } div_state_t;

  div_state_t                       state_r, state_nxt;
  logic [mlem_pkg::NUM_W-1:0]       num_r, num_nxt;
  logic [mlem_pkg::DEN_W-1:0]       den_r, den_nxt;
  logic [mlem_pkg::DEN_W-1:0]       rem_r, rem_nxt;
  logic [mlem_pkg::QUO_W-1:0]       low_r, low_nxt;
  logic [mlem_pkg::QUO_W-1:0]       q_r, q_nxt;
  logic [4:0]                       cnt_r, cnt_nxt;
  logic                             done_r, done_nxt;
  logic [mlem_pkg::DEN_W:0]         rem_sh;
  logic                             take;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign rem_sh = {rem_r, low_r[mlem_pkg::QUO_W-1]};
  assign take   = (rem_sh >= {1'b0, den_r});

  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    low_nxt   = low_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      D_IDLE: begin
        if (start) begin
          num_nxt   = num;
          den_nxt   = den;
          state_nxt = D_CHECK;
        end
      end
      D_CHECK: begin
        // A zero divisor gives zero; a quotient of 2^32 or more saturates.
        if (den_r == '0) begin
          q_nxt     = '0;
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end else if (num_r[mlem_pkg::NUM_W-1:mlem_pkg::QUO_W] >= den_r) begin
          q_nxt     = '1;
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end else begin
          rem_nxt   = num_r[mlem_pkg::NUM_W-1:mlem_pkg::QUO_W];
          low_nxt   = num_r[mlem_pkg::QUO_W-1:0];
          q_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = D_RUN;
        end
      end
      D_RUN: begin
        rem_nxt = take ? mlem_pkg::DEN_W'(rem_sh - {1'b0, den_r})
                       : rem_sh[mlem_pkg::DEN_W-1:0];
        low_nxt = {low_r[mlem_pkg::QUO_W-2:0], 1'b0};
        q_nxt   = {q_r[mlem_pkg::QUO_W-2:0], take};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: sim/mlem_checker.sv
// MLEM reconstruction engine checker: watches all but prdata, predicts and compares results.
`timescale 1ns / 1ps

module mlem_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  mlem_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  mlem_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output int                  errors,
  output int                  results_seen,
  output int                  pending
);
  import mlem_pkg::*;

  localparam int NI_MAX = 256;
  localparam int NO_MAX = 256;
  localparam int ITER_MAX = 100;

  // Shadow copy of the block state.
  logic [31:0] h_mat [0:65535];
  logic [23:0] counts [0:255];
  logic [31:0] est [0:255];
  logic [39:0] colsum [0:255];
  logic [31:0] wimg [0:255];
  logic [31:0] nxt [0:255];
  logic [8:0]  img_bins;
  logic [8:0]  obj_bins;
  logic [6:0]  iters_cfg;

  out_item_t expected_results [$];

  // Floor division with saturation to 32 bits; a zero divisor gives zero.
  function automatic logic [31:0] sat_div(input logic [127:0] num, input logic [63:0] den);
    logic [127:0] q;
    if (den == 0) return 32'd0;
    q = num / den;
    return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  // Column sums, estimate preset and the configured number of updates.
  function automatic void reconstruct();
    int ni, no, nit, i, j, k;
    logic [63:0] acc;
    logic [127:0] prod;
    ni = (img_bins > NI_MAX) ? NI_MAX : img_bins;
    no = (obj_bins > NO_MAX) ? NO_MAX : obj_bins;
    nit = (iters_cfg > ITER_MAX) ? ITER_MAX : iters_cfg;
    for (j = 0; j < no; j++) begin
      acc = 0;
      for (i = 0; i < ni; i++) acc += h_mat[i * NO_MAX + j];
      colsum[j] = acc[39:0];
    end
    for (j = 0; j < NO_MAX; j++) est[j] = ONE_Q16;
    for (k = 0; k < nit; k++) begin
      for (i = 0; i < ni; i++) begin
        acc = 0;
        for (j = 0; j < no; j++) begin
          prod = 128'(h_mat[i * NO_MAX + j]) * 128'(est[j]);
          acc += 64'(prod >> 16);
        end
        wimg[i] = sat_div(128'(counts[i]) << 48, acc);
      end
      for (j = 0; j < no; j++) begin
        acc = 0;
        for (i = 0; i < ni; i++) begin
          prod = 128'(h_mat[i * NO_MAX + j]) * 128'(wimg[i]);
          acc += 64'(prod >> 16);
        end
        nxt[j] = sat_div(128'(acc) * 128'(est[j]), 64'(colsum[j]));
      end
      for (j = 0; j < no; j++) est[j] = nxt[j];
    end
  endfunction

  // Applies one input beat to the shadow state and returns its result.
  function automatic out_item_t predict(input in_item_t item);
    out_item_t r;
    int ni, no;
    ni = (img_bins > NI_MAX) ? NI_MAX : img_bins;
    no = (obj_bins > NO_MAX) ? NO_MAX : obj_bins;
    r = '0;
    case (item.operation)
      OP_LOAD_MATRIX: begin
        if (item.image_index < ni && item.object_index < no)
          h_mat[item.image_index * NO_MAX + item.object_index] = item.load_value;
        else
          r.status = 1'b1;
      end
      OP_LOAD_IMAGE: begin
        if (item.image_index < ni) counts[item.image_index] = item.load_value[23:0];
        else r.status = 1'b1;
      end
      OP_START: reconstruct();
      default: begin
        if (item.object_index < no) r.estimate = est[item.object_index];
        else r.status = 1'b1;
      end
    endcase
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    out_item_t exp_r;
    int bad;
    bad = 0;
    if (!rst_n) begin
      img_bins <= IMAGE_BINS_RST;
      obj_bins <= OBJECT_BINS_RST;
      iters_cfg <= ITERATIONS_RST;
      for (int j = 0; j < 256; j++) est[j] = '0;
      expected_results.delete();
      errors <= 0;
      results_seen <= 0;
    end else begin
      // Register writes on the configuration port.
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_IMAGE_BINS:  img_bins <= pwdata[8:0];
          REG_OBJECT_BINS: obj_bins <= pwdata[8:0];
          REG_ITERATIONS:  iters_cfg <= pwdata[6:0];
          default: ;
        endcase
      end
      // Result beats are compared against the oldest prediction.
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $error("result beat with no prediction waiting");
          bad++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data.status !== exp_r.status) begin
            $error("status expected %0d got %0d", exp_r.status, out_data.status);
            bad++;
          end
          if (out_data.estimate !== exp_r.estimate) begin
            $error("estimate expected %08h got %08h", exp_r.estimate, out_data.estimate);
            bad++;
          end
        end
      end
      if (bad != 0) errors <= errors + bad;
      // Accepted input beats produce predictions.
      if (in_valid && !in_stall)
        expected_results.insert(expected_results.size(), predict(in_data));
    end
  end

endmodule

FILE: sim/tb_top.sv
// Testbench top of the MLEM reconstruction engine: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;
  import mlem_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int ITEM_TARGET = 1500;

  logic clk = 1'b1;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int errors, results_seen, pending;
  int accepted = 0;
  int phases = 0;
  int starts = 0;
  bit no_idle = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  mlem_reconstruction_engine dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mlem_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .errors, .results_seen, .pending
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 7);
    end
  end

  function automatic in_item_t mk(input logic [1:0] op, input int ii, input int oi,
                                  input logic [31:0] val);
    in_item_t it;
    it.operation = op;
    it.image_index = ii[7:0];
    it.object_index = oi[7:0];
    it.load_value = val;
    return it;
  endfunction

  // Offers one beat, with random gaps before it, and waits until it is taken.
  task automatic send_item(input in_item_t item);
    @(negedge clk);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 7) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accepted++;
    if (item.operation == OP_START) starts++;
  endtask

  // Waits until every result is back and the block has finished its work.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while ((results_seen != accepted) || in_stall) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(input int ni, input int no, input int nit);
    wait_idle();
    write_reg(REG_IMAGE_BINS, ni);
    write_reg(REG_OBJECT_BINS, no);
    write_reg(REG_ITERATIONS, nit);
    phases++;
  endtask

  function automatic logic [31:0] matrix_value(input bit tiny);
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return tiny ? 32'($urandom_range(1, 4095)) : $urandom;
    endcase
  endfunction

  function automatic logic [31:0] count_value();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  // Occasional off-pattern beat: reads, stray loads, out-of-range indexes.
  task automatic maybe_noise();
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: send_item(mk(OP_READ, $urandom_range(0, 255), $urandom_range(0, 255), $urandom));
        1: send_item(mk(OP_LOAD_MATRIX, $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom));
        default: send_item(mk(OP_LOAD_IMAGE, $urandom_range(0, 255), 0, $urandom));
      endcase
    end
  endtask

  // One well-formed reconstruction: full matrix and image load, start, reads.
  task automatic run_phase(input int ni_cfg, input int no_cfg, input int nit,
                           input bit tiny, input int reads);
    int ni, no;
    configure(ni_cfg, no_cfg, nit);
    ni = (ni_cfg > 256) ? 256 : ni_cfg;
    no = (no_cfg > 256) ? 256 : no_cfg;
    for (int i = 0; i < ni; i++) begin
      for (int j = 0; j < no; j++) begin
        maybe_noise();
        send_item(mk(OP_LOAD_MATRIX, i, j, matrix_value(tiny)));
      end
    end
    for (int i = 0; i < ni; i++) begin
      maybe_noise();
      send_item(mk(OP_LOAD_IMAGE, i, $urandom_range(0, 255), count_value()));
    end
    send_item(mk(OP_START, $urandom_range(0, 255), $urandom_range(0, 255), $urandom));
    for (int k = 0; k < reads; k++) begin
      if ($urandom_range(0, 3) != 0)
        send_item(mk(OP_READ, $urandom_range(0, 255), $urandom_range(0, no - 1), $urandom));
      else
        send_item(mk(OP_READ, $urandom_range(0, 255), $urandom_range(0, 255), $urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset estimates, extreme loads, empty and degenerate starts.
    send_item(mk(OP_READ, 0, 0, 32'd0));
    send_item(mk(OP_READ, 255, 255, 32'hFFFF_FFFF));
    send_item(mk(OP_LOAD_MATRIX, 255, 255, 32'hFFFF_FFFF));
    send_item(mk(OP_LOAD_MATRIX, 0, 0, 32'd0));
    send_item(mk(OP_LOAD_IMAGE, 255, 255, 32'hFFFF_FFFF));
    send_item(mk(OP_LOAD_IMAGE, 0, 0, 32'd0));
    configure(0, 256, 0);
    send_item(mk(OP_START, 0, 0, 32'd0));
    send_item(mk(OP_READ, 0, 0, 32'd0));
    send_item(mk(OP_READ, 0, 255, 32'd0));
    send_item(mk(OP_LOAD_IMAGE, 0, 0, 32'd5));
    configure(0, 1, 127);
    send_item(mk(OP_START, 255, 255, 32'hFFFF_FFFF));
    send_item(mk(OP_READ, 0, 0, 32'd0));
    send_item(mk(OP_READ, 0, 1, 32'd0));
    send_item(mk(OP_LOAD_MATRIX, 0, 1, 32'd7));
    configure(0, 0, 1);
    send_item(mk(OP_START, 0, 0, 32'd0));
    send_item(mk(OP_READ, 0, 0, 32'd0));
    wait_idle();
    write_reg(REG_SPARE, 32'hFFFF_FFFF);

    // Fixed phases: deep iteration, oversized bin counts, receiver hold-off.
    run_phase(4, 4, 3, 1'b0, 6);
    run_phase(2, 3, 100, 1'b1, 4);
    hold_req++;
    run_phase(511, 1, 2, 1'b1, 3);
    run_phase(1, 511, 1, 1'b1, 6);

    // Random phases, one of them with no idling on either side.
    while (accepted < ITEM_TARGET) begin
      if (phases == 12) no_idle = 1'b1;
      run_phase($urandom_range(1, 8), $urandom_range(1, 8),
                ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6),
                $urandom_range(0, 1), $urandom_range(2, 10));
      no_idle = 1'b0;
    end

    wait_idle();
    repeat (50) @(posedge clk);
    $display("Run covered %0d items in %0d register settings with %0d reconstructions.",
             accepted, phases, starts);
    $display("%0d result beats were checked against the prediction.", results_seen);
    if (errors == 0 && pending == 0) begin
      $display("mlem_reconstruction_engine: match");
    end else begin
      $display("mlem_reconstruction_engine: mismatch");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #8000000;
    $display("mlem_reconstruction_engine: mismatch");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/mlem_pkg.sv
hw/rtl/mlem_ram.sv
hw/rtl/mlem_div.sv
hw/rtl/mlem_reconstruction_engine.sv
sim/mlem_checker.sv
sim/tb_top.sv
